// File: rtl/arrc_pkg.sv
`default_nettype none
package arrc_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int MAX_SAMPLES = 64;
  localparam int SUM_W       = 16;
  localparam int CNT_W       = 7;
  localparam int REF_W       = 10;
  localparam int AVG_W       = 10;
  localparam int RATIO_W     = 16;
  localparam int FRAC_BITS   = 12;
  localparam int DIVD_W      = REF_W + FRAC_BITS;
  localparam int DIVS_W      = SUM_W;
  localparam int ITER_W      = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [REF_W-1:0] REF_RESET   = 10'd512;
  localparam logic [REF_W-1:0] TOL_RESET   = 10'd64;
  localparam logic [CNT_W-1:0] COUNT_RESET = 7'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REFERENCE    = 2'd0,
    CFG_TOLERANCE    = 2'd1,
    CFG_SAMPLE_COUNT = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic accumulate;
    logic start_avg;
    logic load_avg;
    logic start_ratio;
    logic finish;
  } arrc_cmd_t;

  typedef struct packed {
    logic complete;
    logic div_busy;
    logic out_free;
  } arrc_status_t;

endpackage
`default_nettype wire

// File: rtl/arrc_sample_if.sv
`default_nettype none
interface arrc_sample_if;
  import arrc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);

endinterface
`default_nettype wire

// File: rtl/arrc_result_if.sv
`default_nettype none
interface arrc_result_if;
  import arrc_pkg::*;

  logic               valid;
  logic               ready;
  logic [RATIO_W-1:0] correction_ratio;
  logic [AVG_W-1:0]   average;
  logic               replaced;
  logic               saturated;

  modport source (output valid, output correction_ratio, output average,
                  output replaced, output saturated, input ready);
  modport sink (input valid, input correction_ratio, input average,
                input replaced, input saturated, output ready);

endinterface
`default_nettype wire

// File: rtl/arrc_div.sv
`default_nettype none
module arrc_div
  import arrc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [ITER_W-1:0] iters,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [DIVS_W-1:0] divisor,
  output logic                   busy,
  output logic [DIVD_W-1:0]      quotient
);

  logic [DIVD_W-1:0] q;
  logic [DIVS_W-1:0] r;
  logic [DIVS_W-1:0] d;
  logic [ITER_W-1:0] cnt;
  logic [DIVS_W:0]   r_shift;
  logic              ge;
  logic [DIVS_W:0]   r_sub;

  // restoring division, one quotient bit per cycle
  always_comb begin
    r_shift = {r, q[DIVD_W-1]};
    ge      = r_shift >= {1'b0, d};
    r_sub   = r_shift - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= iters;
    end else if (busy) begin
      cnt <= cnt - ITER_W'(1);
      if (cnt == ITER_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      q <= {q[DIVD_W-2:0], ge};
      r <= ge ? r_sub[DIVS_W-1:0] : r_shift[DIVS_W-1:0];
    end
  end

  assign quotient = q;

endmodule
`default_nettype wire

// File: rtl/arrc_ctrl.sv
`default_nettype none
module arrc_ctrl
  import arrc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire arrc_status_t status,
  output arrc_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG_START,
    S_AVG_WAIT,
    S_RATIO_START,
    S_RATIO_WAIT,
    S_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && status.complete) begin
            state <= S_AVG_START;
          end
        end
        S_AVG_START: state <= S_AVG_WAIT;
        S_AVG_WAIT: begin
          if (!status.div_busy) begin
            state <= S_RATIO_START;
          end
        end
        S_RATIO_START: state <= S_RATIO_WAIT;
        S_RATIO_WAIT: begin
          if (!status.div_busy) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready        = state == S_IDLE;
    cmd.accumulate  = (state == S_IDLE) && in_valid;
    cmd.start_avg   = state == S_AVG_START;
    cmd.load_avg    = (state == S_AVG_WAIT) && !status.div_busy;
    cmd.start_ratio = state == S_RATIO_START;
    cmd.finish      = (state == S_FINISH) && status.out_free;
  end

endmodule
`default_nettype wire

// File: rtl/arrc_datapath.sv
`default_nettype none
module arrc_datapath
  import arrc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire arrc_cmd_t              cmd,
  output arrc_status_t                status,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output logic [RATIO_W-1:0]          out_ratio,
  output logic [AVG_W-1:0]            out_average,
  output logic                        out_replaced,
  output logic                        out_saturated
);

  logic [REF_W-1:0]  reference_value;
  logic [REF_W-1:0]  tolerance;
  logic [CNT_W-1:0]  sample_count;
  logic [SUM_W-1:0]  running_sum;
  logic [CNT_W-1:0]  samples_taken;
  logic [DIVS_W-1:0] avg_final;
  logic              replaced;

  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  taken_next;
  logic [SUM_W-1:0]  ref_ext;
  logic [SUM_W-1:0]  avg_raw;
  logic [SUM_W-1:0]  diff;
  logic              repl_next;
  logic              sat;

  logic              div_start;
  logic [ITER_W-1:0] div_iters;
  logic [DIVD_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;
  logic              div_busy;
  logic [DIVD_W-1:0] div_quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_value <= REF_RESET;
      tolerance       <= TOL_RESET;
      sample_count    <= COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_REFERENCE:    reference_value <= cfg_data[REF_W-1:0];
        CFG_TOLERANCE:    tolerance       <= cfg_data[REF_W-1:0];
        CFG_SAMPLE_COUNT: sample_count    <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sample_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (sample_count > CNT_W'(MAX_SAMPLES)) begin
      n_eff = CNT_W'(MAX_SAMPLES);
    end else begin
      n_eff = sample_count;
    end
    taken_next = samples_taken + CNT_W'(1);
    ref_ext    = {{(SUM_W-REF_W){1'b0}}, reference_value};
    avg_raw    = div_quotient[SUM_W-1:0];
    diff       = (avg_raw > ref_ext) ? (avg_raw - ref_ext) : (ref_ext - avg_raw);
    repl_next  = diff > {{(SUM_W-REF_W){1'b0}}, tolerance};
    sat        = (avg_final == '0) || (div_quotient[DIVD_W-1:RATIO_W] != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      samples_taken <= '0;
    end else if (cmd.finish) begin
      running_sum   <= '0;
      samples_taken <= '0;
    end else if (cmd.accumulate) begin
      running_sum   <= running_sum + {{(SUM_W-SAMPLE_BITS){1'b0}}, sample};
      samples_taken <= taken_next;
    end
  end

  // average first (sum / n), then ratio ((ref << 12) / average) on the same divider
  always_comb begin
    div_start = cmd.start_avg || cmd.start_ratio;
    if (cmd.start_ratio) begin
      div_iters    = ITER_W'(DIVD_W);
      div_dividend = {reference_value, {FRAC_BITS{1'b0}}};
      div_divisor  = avg_final;
    end else begin
      div_iters    = ITER_W'(SUM_W);
      div_dividend = {running_sum, {(DIVD_W-SUM_W){1'b0}}};
      div_divisor  = {{(DIVS_W-CNT_W){1'b0}}, n_eff};
    end
  end

  arrc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .iters    (div_iters),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_avg) begin
      avg_final <= repl_next ? ref_ext : avg_raw;
      replaced  <= repl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_ratio     <= sat ? {RATIO_W{1'b1}} : div_quotient[RATIO_W-1:0];
      out_average   <= avg_final[AVG_W-1:0];
      out_replaced  <= replaced;
      out_saturated <= sat;
    end
  end

  always_comb begin
    status.complete = taken_next >= n_eff;
    status.div_busy = div_busy;
    status.out_free = !out_valid || out_ready;
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.start_avg || cmd.start_ratio) |-> !div_busy)
    else $error("divider started while busy");
  a_taken_bound: assert property (@(posedge clk) disable iff (rst)
    samples_taken <= CNT_W'(MAX_SAMPLES))
    else $error("sample counter beyond block size");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result overwrote pending beat");
  a_finish_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (samples_taken == '0 && running_sum == '0 && out_valid))
    else $error("block state not cleared after result");
`endif

endmodule
`default_nettype wire

// File: rtl/adc_reference_ratio_calibrator_unit.sv
// ADC reference ratio calibrator.
// samples: valid/ready channel of raw reference conversions, one per beat.
// results: valid/ready channel; one beat per completed block of samples with
//   correction_ratio (unsigned Q4.12), average, replaced and saturated.
// cfg_write/cfg_index/cfg_data: register writes, taken at any clock edge with
//   cfg_write high: 0 reference_value, 1 tolerance, 2 sample_count.
// Samples are accepted one per cycle while accumulating. The beat that
// completes a block starts two passes of the shared divider, first for the
// average and then for the ratio; the result is then loaded into the output
// register once it is free, and samples are held off until that happens.
// The result sits in an output register; if the receiver stalls, the next
// block is still accumulated, and its result waits until the register frees.
// Synchronous reset restores the register defaults (512, 64, 16), clears the
// sum and the sample counter and drops any pending result.
`default_nettype none
module adc_reference_ratio_calibrator_unit
  import arrc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  arrc_sample_if.sink                samples,
  arrc_result_if.source              results,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  arrc_cmd_t    cmd;
  arrc_status_t status;
  logic         in_ready;

  arrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign samples.ready = in_ready;

  arrc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample        (samples.sample),
    .cmd           (cmd),
    .status        (status),
    .out_ready     (results.ready),
    .out_valid     (results.valid),
    .out_ratio     (results.correction_ratio),
    .out_average   (results.average),
    .out_replaced  (results.replaced),
    .out_saturated (results.saturated)
  );

endmodule
`default_nettype wire

// File: verif/ratio_result_checker.sv
module ratio_result_checker
  import arrc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  arrc_sample_if                     smp,
  arrc_result_if                     res,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         mismatches,
  output int                         outstanding
);

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [AVG_W-1:0]   average;
    logic               replaced;
    logic               saturated;
  } ratio_beat_t;

  logic [REF_W-1:0] ref_code;
  logic [REF_W-1:0] tol_code;
  logic [CNT_W-1:0] count_cfg;
  logic [SUM_W-1:0] sum_acc;
  logic [CNT_W-1:0] taken;
  ratio_beat_t      expected_ratios[$];

  function automatic int unsigned block_size(input logic [CNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > MAX_SAMPLES) return MAX_SAMPLES;
    return c;
  endfunction

  always @(posedge clk) begin : track
    int unsigned n;
    int unsigned avg;
    int unsigned diff;
    int unsigned quot;
    ratio_beat_t want;
    ratio_beat_t got;
    if (rst) begin
      ref_code = REF_RESET;
      tol_code = TOL_RESET;
      count_cfg = COUNT_RESET;
      sum_acc = '0;
      taken = '0;
      expected_ratios.delete();
      mismatches = 0;
    end else begin
      if (res.valid && res.ready) begin
        got = {res.correction_ratio, res.average, res.replaced, res.saturated};
        if (expected_ratios.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: ratio %0d average %0d replaced %0b saturated %0b",
                   $time, got.ratio, got.average, got.replaced, got.saturated);
        end else begin
          want = expected_ratios.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: result mismatch: expected ratio %0d average %0d replaced %0b saturated %0b",
                     $time, want.ratio, want.average, want.replaced, want.saturated);
            $display("%0t:                    actual ratio %0d average %0d replaced %0b saturated %0b",
                     $time, got.ratio, got.average, got.replaced, got.saturated);
          end
        end
      end

      if (cfg_write) begin
        case (cfg_index)
          CFG_REFERENCE:    ref_code = cfg_data[REF_W-1:0];
          CFG_TOLERANCE:    tol_code = cfg_data[REF_W-1:0];
          CFG_SAMPLE_COUNT: count_cfg = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end

      if (smp.valid && smp.ready) begin
        n = block_size(count_cfg);
        sum_acc = sum_acc + smp.sample;
        taken = taken + 1'b1;
        if (taken >= n) begin
          avg = sum_acc / n;
          diff = (avg > ref_code) ? avg - ref_code : ref_code - avg;
          want.replaced = (diff > tol_code);
          if (want.replaced) avg = ref_code;
          // zero average and quotient overflow both pin the ratio at full scale
          if (avg == 0) begin
            quot = 32'hFFFF;
            want.saturated = 1'b1;
          end else begin
            quot = (int'(ref_code) << FRAC_BITS) / avg;
            want.saturated = (quot > 32'hFFFF);
            if (want.saturated) quot = 32'hFFFF;
          end
          want.ratio = quot[RATIO_W-1:0];
          want.average = avg[AVG_W-1:0];
          expected_ratios.push_back(want);
          sum_acc = '0;
          taken = '0;
        end
      end
    end
    outstanding = expected_ratios.size();
  end

endmodule

// File: verif/tb_adc_reference_ratio_calibrator_unit.sv
module tb_adc_reference_ratio_calibrator_unit;
  import arrc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 60;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;
  bit                    hold_req;
  bit                    rx_idle;
  bit                    tx_idle;

  arrc_sample_if smp();
  arrc_result_if res();

  adc_reference_ratio_calibrator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (smp),
    .results   (res),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ratio_result_checker ratio_check (
    .clk         (clk),
    .rst         (rst),
    .smp         (smp),
    .res         (res),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [9:0] ref_val, input logic [9:0] tol_val,
                           input logic [9:0] cnt_val);
    write_reg(CFG_REFERENCE, ref_val);
    write_reg(CFG_TOLERANCE, tol_val);
    write_reg(CFG_SAMPLE_COUNT, cnt_val);
    cfg_write <= 1'b0;
  endtask

  task automatic put_sample(input logic [SAMPLE_BITS-1:0] value);
    smp.valid <= 1'b1;
    smp.sample <= value;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
  endtask

  // stop offering, wait for every expected result, then let a partial block settle
  task automatic settle;
    smp.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] draw_sample(input int center, input int spread);
    int v;
    case ($urandom_range(0, 9))
      0: return SAMPLE_BITS'($urandom);
      1: return $urandom_range(0, 1) ? '0 : '1;
      default: begin
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return SAMPLE_BITS'(v);
      end
    endcase
  endfunction

  // receiver side: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        res.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int ref_v;
    int tol_v;
    int cnt_v;
    int center;
    int spread;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= CFG_REFERENCE;
    cfg_data <= '0;
    smp.valid <= 1'b0;
    smp.sample <= '0;
    hold_req = 1'b0;
    rx_idle = 1'b0;
    tx_idle = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults, one full block
    for (int i = 0; i < 16; i++) put_sample(SAMPLE_BITS'(500 + i));
    settle();

    // wide tolerance: ratio overflow, unity, zero average
    configure(10'd1023, 10'd1023, 10'd1);
    put_sample(10'd1);
    put_sample(10'd1023);
    put_sample(10'd0);
    settle();

    // zero tolerance: exact, replaced above, replaced below
    configure(10'd512, 10'd0, 10'd1);
    put_sample(10'd512);
    put_sample(10'd513);
    put_sample(10'd511);
    put_sample(10'd0);
    settle();

    // count of zero acts as one; zero reference forces a zero average
    configure(10'd0, 10'd0, 10'h380);
    put_sample(10'd5);
    settle();
    write_reg(CFG_SPARE, 10'h3FF);
    cfg_write <= 1'b0;

    // count lowered mid-block; average wider than its field
    configure(10'd1023, 10'd1023, 10'd8);
    repeat (3) put_sample(10'd1023);
    settle();
    configure(10'd1023, 10'd1023, 10'd2);
    put_sample(10'd1023);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      ref_v = $urandom_range(0, 1023);
      tol_v = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 1023);
      case (p)
        0: begin ref_v = 1023; tol_v = 0; end
        1: begin ref_v = 0; tol_v = 1023; end
        default: ;
      endcase
      cnt_v = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
      case (p)
        2: cnt_v = 1;
        3: cnt_v = 0;
        4: cnt_v = 127;
        5: cnt_v = 64;
        6: cnt_v = $urandom_range(65, 126);
        default: ;
      endcase
      tx_idle = (p != NUM_PHASES - 1);
      rx_idle = tx_idle;
      configure(10'(ref_v), 10'(tol_v), {3'($urandom_range(0, 7)), 7'(cnt_v)});
      if (p == 2) hold_req = 1'b1;
      center = ref_v;
      spread = 1 + tol_v / 4;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 15) == 0)
          center = ref_v + int'($urandom_range(0, 4 * tol_v + 16)) - (2 * tol_v + 8);
        put_sample(draw_sample(center, spread));
        if (tx_idle && $urandom_range(0, 4) == 0) begin
          smp.valid <= 1'b0;
          repeat ($urandom_range(1, 17)) @(posedge clk);
        end
      end
      settle();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
